// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/edt_pkg.sv =====
package edt_pkg;

  localparam int MAX_TRIGGERS_DEF = 16;

  // Operation codes.
  localparam logic [2:0] OP_SAMPLE  = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_ENABLE  = 3'd3;
  localparam logic [2:0] OP_DISABLE = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_REARM   = 3'd6;
  localparam logic [2:0] OP_QUERY   = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Source codes.
  localparam logic [2:0] SRC_LEFT  = 3'd0;
  localparam logic [2:0] SRC_RIGHT = 3'd1;
  localparam logic [2:0] SRC_MEAN  = 3'd2;
  localparam logic [2:0] SRC_ABS   = 3'd3;
  localparam logic [2:0] SRC_DIFF  = 3'd4;

  // Compare codes.
  localparam logic [2:0] CMP_GT   = 3'd0;
  localparam logic [2:0] CMP_LT   = 3'd1;
  localparam logic [2:0] CMP_NEAR = 3'd2;
  localparam logic [2:0] CMP_GE   = 3'd3;
  localparam logic [2:0] CMP_LE   = 3'd4;

  // Flag bit positions.
  localparam int FL_ONESHOT = 6;
  localparam int FL_ACTIVE  = 7;
  localparam int FL_FIRED   = 8;

  localparam int NEAR_TOL = 66;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic act;
    logic derive;
    logic check;
    logic fin;
  } edt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       at_end;
    logic       hit;
    logic       active;
  } edt_sts_t;

  // Value derived from the wheel distances.
  function automatic logic signed [32:0] derive_val(
      input logic [2:0] src, input logic signed [31:0] l, input logic signed [31:0] r);
    logic signed [32:0] s;
    logic [32:0] al;
    logic [32:0] ar;
    logic [32:0] as;
    s  = 33'(l) + 33'(r);
    al = l[31] ? (33'd0 - 33'(l)) : 33'(l);
    ar = r[31] ? (33'd0 - 33'(r)) : 33'(r);
    as = al + ar;
    case (src)
      SRC_LEFT:  derive_val = 33'(l);
      SRC_RIGHT: derive_val = 33'(r);
      SRC_MEAN:  derive_val = s >>> 1;
      SRC_ABS:   derive_val = as[32] ? 33'h0_FFFF_FFFF : as;
      SRC_DIFF:  derive_val = 33'(l) - 33'(r);
      default:   derive_val = '0;
    endcase
  endfunction

  // Trigger condition.
  function automatic logic cond_met(
      input logic [2:0] cmp, input logic signed [32:0] v, input logic signed [31:0] t);
    logic signed [33:0] d;
    logic signed [32:0] te;
    te = 33'(t);
    d  = 34'(v) - 34'(te);
    case (cmp)
      CMP_GT:   cond_met = v > te;
      CMP_LT:   cond_met = v < te;
      CMP_NEAR: cond_met = (d < 34'sd66) && (d > -34'sd66);
      CMP_GE:   cond_met = v >= te;
      CMP_LE:   cond_met = v <= te;
      default:  cond_met = 1'b0;
    endcase
  endfunction

endpackage

// ===== rtl/core/edt_ctrl.sv =====
module edt_ctrl
  import edt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  edt_sts_t sts,
  output edt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_DER  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Sequencing of lookups, actions and the sample scan.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // The op arrives with start; the datapath latches it this edge.
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (sts.op == OP_SAMPLE) begin
          state_nxt = S_DER;
        end else if (sts.op inside {OP_ADD, OP_CLEAR, OP_REARM}) begin
          state_nxt = S_ACT;
        end else if (sts.at_end || sts.hit) begin
          state_nxt = S_ACT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DER: begin
        if (sts.at_end) begin
          state_nxt = S_END;
        end else if (!sts.active) begin
          cmd.step = 1'b1;
        end else begin
          cmd.derive = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = S_DER;
      end
      S_END: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/edt_datapath.sv =====
`include "assert_macros.svh"

module edt_datapath
  import edt_pkg::*;
#(
  parameter int N = MAX_TRIGGERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_left_distance,
  input  logic signed [31:0] in_right_distance,
  input  logic [31:0]        in_trigger_id,
  input  logic [2:0]         in_source_kind,
  input  logic [2:0]         in_compare_kind,
  input  logic signed [31:0] in_target,
  input  logic               in_one_shot,
  input  edt_cmd_t           cmd,
  output edt_sts_t           sts,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic               out_ok,
  output logic [31:0]        out_fired_id,
  output logic signed [32:0] out_fired_value,
  output logic [4:0]         out_fired_count,
  output logic               out_last
);

  localparam int CW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  // Trigger table.
  logic [31:0] id_r  [N];
  logic [31:0] tgt_r [N];
  logic [8:0]  flg_r [N];

  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   next_id_r;
  logic [4:0]    fcnt_r;

  // Latched item.
  logic [2:0]         op_r;
  logic signed [31:0] left_r, right_r;
  logic [31:0]        tid_r;
  logic [2:0]         src_r, cmp_r;
  logic [31:0]        tgt_in_r;
  logic               os_r;
  logic signed [32:0] val_r;

  // Output register.
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic               out_ok_r;
  logic [31:0]        out_id_r;
  logic signed [32:0] out_val_r;
  logic [4:0]         out_cnt_r;
  logic               out_last_r;

  logic [IW-1:0] ix;
  logic [IW-1:0] cix;
  logic [31:0]   e_id;
  logic [31:0]   e_tgt;
  logic [8:0]    e_flg;
  logic          at_end;
  logic          full;
  logic          met;
  logic          fire;
  logic          rearm_one;
  logic          shift_en;
  logic          add_ok;
  logic [31:0]   id_inc;

  // Current entry, selected by the scan index.
  assign ix     = idx_r[IW-1:0];
  assign cix    = count_r[IW-1:0];
  assign e_id   = id_r[ix];
  assign e_tgt  = tgt_r[ix];
  assign e_flg  = flg_r[ix];
  assign at_end = (idx_r >= count_r);
  assign full   = (count_r >= CW'(N));
  assign add_ok = !full;
  assign id_inc = next_id_r + 32'd1;

  // Compare of the registered derived value.
  assign met       = cond_met(e_flg[5:3], val_r, e_tgt);
  assign fire      = cmd.check && met && !e_flg[FL_FIRED];
  assign rearm_one = cmd.check && !met && e_flg[FL_FIRED] && !e_flg[FL_ONESHOT];
  assign shift_en  = (cmd.act && op_r == OP_REMOVE && !at_end)
                   || (fire && e_flg[FL_ONESHOT]);

  assign sts.op     = op_r;
  assign sts.at_end = at_end;
  assign sts.hit    = (e_id == tid_r);
  assign sts.active = e_flg[FL_ACTIVE];

  // Table writes, including the compacting shift on removal.
  // A one-shot entry that fires is removed by the shift alone.
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      case (op_r)
        OP_ADD: begin
          if (add_ok) begin
            id_r[cix]  <= next_id_r;
            tgt_r[cix] <= tgt_in_r;
            flg_r[cix] <= {1'b0, 1'b1, os_r, cmp_r, src_r};
          end
        end
        OP_ENABLE: begin
          if (!at_end) flg_r[ix][FL_ACTIVE] <= 1'b1;
        end
        OP_DISABLE: begin
          if (!at_end) flg_r[ix][FL_ACTIVE] <= 1'b0;
        end
        OP_REARM: begin
          for (int i = 0; i < N; i++) flg_r[i][FL_FIRED] <= 1'b0;
        end
        default: ;
      endcase
    end
    if (fire && !e_flg[FL_ONESHOT]) flg_r[ix][FL_FIRED] <= 1'b1;
    if (rearm_one) flg_r[ix][FL_FIRED] <= 1'b0;
    if (shift_en) begin
      for (int i = 0; i < N - 1; i++) begin
        if (CW'(i) >= idx_r) begin
          id_r[i]  <= id_r[i+1];
          tgt_r[i] <= tgt_r[i+1];
          flg_r[i] <= flg_r[i+1];
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      next_id_r   <= 32'd1;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.act || fire || cmd.fin;
      if (cmd.load) begin
        idx_r  <= '0;
        fcnt_r <= '0;
      end else if (cmd.step || (cmd.check && !shift_en)) begin
        idx_r <= idx_r + CW'(1);
      end
      if (fire) fcnt_r <= fcnt_r + 5'd1;
      if (cmd.act && op_r == OP_ADD && add_ok) begin
        count_r   <= count_r + CW'(1);
        next_id_r <= (id_inc == 32'd0) ? 32'd1 : id_inc;
      end else if (cmd.act && op_r == OP_CLEAR) begin
        count_r <= '0;
      end else if (shift_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Item latch, derived value and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      left_r   <= in_left_distance;
      right_r  <= in_right_distance;
      tid_r    <= in_trigger_id;
      src_r    <= in_source_kind;
      cmp_r    <= in_compare_kind;
      tgt_in_r <= in_target;
      os_r     <= in_one_shot;
    end
    if (cmd.derive) val_r <= derive_val(e_flg[2:0], left_r, right_r);
    if (cmd.act) begin
      out_kind_r <= KIND_REPLY;
      out_val_r  <= '0;
      out_cnt_r  <= '0;
      out_last_r <= 1'b1;
      out_id_r   <= (op_r == OP_ADD && add_ok) ? next_id_r : 32'd0;
      case (op_r)
        OP_ADD:   out_ok_r <= add_ok;
        OP_QUERY: out_ok_r <= !at_end && e_flg[FL_ACTIVE];
        OP_CLEAR, OP_REARM: out_ok_r <= 1'b1;
        default:  out_ok_r <= !at_end;
      endcase
    end else if (fire) begin
      out_kind_r <= KIND_FIRED;
      out_ok_r   <= 1'b1;
      out_id_r   <= e_id;
      out_val_r  <= val_r;
      out_cnt_r  <= '0;
      out_last_r <= 1'b0;
    end else if (cmd.fin) begin
      out_kind_r <= KIND_END;
      out_ok_r   <= 1'b1;
      out_id_r   <= '0;
      out_val_r  <= '0;
      out_cnt_r  <= fcnt_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_ok          = out_ok_r;
  assign out_fired_id    = out_id_r;
  assign out_fired_value = out_val_r;
  assign out_fired_count = out_cnt_r;
  assign out_last        = out_last_r;

  // The table never holds more entries than it has room for.
  `ASSERT_SAME(a_count_range, 1'b1, count_r <= CW'(N))
  // A new item always starts its scan at the first entry.
  `ASSERT_NEXT(a_load_idx, cmd.load, idx_r == '0)
  // A firing is counted in the cycle after it is found.
  `ASSERT_NEXT(a_fire_count, fire && !cmd.load, fcnt_r == $past(fcnt_r) + 5'd1)

endmodule

// ===== rtl/core/encoder_distance_trigger_table.sv =====
// Distance trigger table. An item is taken when start is high and busy is low;
// results then appear on the out_ ports for one cycle each, marked by out_valid,
// and the receiver cannot stall them. Every operation but sample ends in one
// reply item. Add, clear all and re-arm all go to their action without a lookup;
// remove, enable, disable and query look the id up one entry per cycle, stopping
// at a match or at the end of the table. A sample walks the table one entry at a
// time: an inactive entry is skipped, and an active one has its value derived,
// then compared. It emits one item per firing and then an end item with the
// firing count.
module encoder_distance_trigger_table
  import edt_pkg::*;
#(
  parameter int MAX_TRIGGERS = MAX_TRIGGERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_left_distance,
  input  logic signed [31:0] in_right_distance,
  input  logic [31:0]        in_trigger_id,
  input  logic [2:0]         in_source_kind,
  input  logic [2:0]         in_compare_kind,
  input  logic signed [31:0] in_target,
  input  logic               in_one_shot,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic               out_ok,
  output logic [31:0]        out_fired_id,
  output logic signed [32:0] out_fired_value,
  output logic [4:0]         out_fired_count,
  output logic               out_last
);

  edt_cmd_t cmd;
  edt_sts_t sts;

  // Sequencer.
  edt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Table and arithmetic.
  edt_datapath #(.N(MAX_TRIGGERS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_left_distance  (in_left_distance),
    .in_right_distance (in_right_distance),
    .in_trigger_id     (in_trigger_id),
    .in_source_kind    (in_source_kind),
    .in_compare_kind   (in_compare_kind),
    .in_target         (in_target),
    .in_one_shot       (in_one_shot),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_ok            (out_ok),
    .out_fired_id      (out_fired_id),
    .out_fired_value   (out_fired_value),
    .out_fired_count   (out_fired_count),
    .out_last          (out_last)
  );

endmodule
